>>> sv/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// shared types and constants of the cubic curve sampler
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 24;
    localparam int IDX_W     = 6;
    localparam int T_BITS    = 16;
    localparam int LEN_FRAC  = 4;
    localparam int SQ_IN_W   = 42;   // (sum of two 16 bit diff^2 + 8 fraction bits) upper bound
    localparam int SQ_OUT_W  = 21;
    localparam int TOT_W     = 23;
    localparam int CNT_W     = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_LOAD,
        S_SQ_RUN,
        S_DIV,
        S_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TDIV,
        B_LERP,
        B_OUT
    } t_back_state;

endpackage

>>> sv/cbs_if.sv
// ----------------------------------------------------------------------------
// cbs_in_if / cbs_out_if
// valid/ready channels for curve items and sample items
// ----------------------------------------------------------------------------
interface cbs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] p0_x;
    logic [15:0] p0_y;
    logic [15:0] p1_x;
    logic [15:0] p1_y;
    logic [15:0] p2_x;
    logic [15:0] p2_y;
    logic [15:0] p3_x;
    logic [15:0] p3_y;
    modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                    input ready);
    modport sink (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  output ready);
endinterface

interface cbs_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] point_x;
    logic [23:0] point_y;
    logic [5:0]  sample_index;
    logic        last;
    modport source (output valid, point_x, point_y, sample_index, last, input ready);
    modport sink (input valid, point_x, point_y, sample_index, last, output ready);
endinterface

>>> sv/cubic_bezier_sampler.sv
// ----------------------------------------------------------------------------
// cubic_bezier_sampler
// samples a cubic curve from four control points at a spacing along its polygon
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// in_ch    in   valid/ready   p0..p3 x/y
// out_ch   out  valid/ready   point_x, point_y, sample_index, last
// cfg      in   i_cfg_we      i_cfg_data (sample_interval)
// front: a bit-serial square root for each of the three legs, then a
// restoring divider for the point count; back: a serial divider for t and
// lerp steps for each sample. a two-entry queue lets the front take a new curve
// while the back drains. reset is synchronous; the interval resets to 1.
// ----------------------------------------------------------------------------
module cubic_bezier_sampler #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    cbs_in_if.sink      in_ch,
    cbs_out_if.source   out_ch
);
    localparam int QW = 8 * COORD_BITS + cbs_pkg::CNT_W;

    logic [15:0] r_interval;
    logic push, full, pop, empty;
    logic [8*COORD_BITS-1:0] f_pts, b_pts;
    logic [cbs_pkg::CNT_W-1:0] f_cnt, b_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)     r_interval <= 16'd1;
        else if (i_cfg_we) r_interval <= i_cfg_data;
    end

    cbs_front #(.COORD_BITS(COORD_BITS), .MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk, .i_rst_n, .i_interval(r_interval), .in_ch,
        .o_push(push), .i_full(full), .o_pts(f_pts), .o_count(f_cnt)
    );

    cbs_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data({f_cnt, f_pts}), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data({b_cnt, b_pts})
    );

    cbs_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_pts(b_pts), .i_count(b_cnt),
        .o_pop(pop), .out_ch
    );
endmodule

>>> sv/cbs_front.sv
// ----------------------------------------------------------------------------
// cbs_front
// accepts a curve item, sums the three leg lengths and derives the point count
// ----------------------------------------------------------------------------
module cbs_front #(
    parameter int COORD_BITS = 16,
    parameter int MAX_POINTS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [15:0]             i_interval,
    cbs_in_if.sink                  in_ch,
    output logic                    o_push,
    input  logic                    i_full,
    output logic [8*COORD_BITS-1:0] o_pts,
    output logic [cbs_pkg::CNT_W-1:0] o_count
);
    localparam int SQ_W  = 2 * COORD_BITS + 10;
    localparam int RES_W = SQ_W / 2 + 1;
    localparam int TOT_W = RES_W + 2;
    localparam int ITER  = SQ_W / 2;
    localparam int IT_W  = $clog2(ITER + 1);
    localparam int DIV_W = TOT_W;

    cbs_pkg::t_front_state r_state, n_state;
    logic [8*COORD_BITS-1:0] r_pts;
    logic [1:0]      r_leg;
    logic [SQ_W-1:0] r_rem, r_res, r_bit;
    logic [IT_W-1:0] r_it;
    logic [TOT_W-1:0] r_tot, r_quo, r_drem;
    logic [5:0]      r_dn;
    logic [cbs_pkg::CNT_W-1:0] r_count;

    logic [COORD_BITS-1:0] ax, ay, bx, by, dx, dy;
    logic [SQ_W-1:0] sq;
    logic [SQ_W-1:0] trial;
    logic [DIV_W:0]  dsh;
    logic [19:0]     divisor;

    always_comb begin
        ax = r_pts[(2*r_leg)*COORD_BITS +: COORD_BITS];
        ay = r_pts[(2*r_leg+1)*COORD_BITS +: COORD_BITS];
        bx = r_pts[(2*r_leg+2)*COORD_BITS +: COORD_BITS];
        by = r_pts[(2*r_leg+3)*COORD_BITS +: COORD_BITS];
        dx = (ax >= bx) ? ax - bx : bx - ax;
        dy = (ay >= by) ? ay - by : by - ay;
        sq = (SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy)) << 8;
        trial = r_res + r_bit;
        divisor = {(i_interval == 16'd0) ? 16'd1 : i_interval, 4'd0};
        dsh = {r_drem, r_tot[TOT_W-1]};
    end

    assign in_ch.ready = (r_state == cbs_pkg::S_IDLE);
    assign o_pts   = r_pts;
    assign o_count = r_count;

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            cbs_pkg::S_IDLE:    if (in_ch.valid) n_state = cbs_pkg::S_SQ_LOAD;
            cbs_pkg::S_SQ_LOAD: n_state = cbs_pkg::S_SQ_RUN;
            cbs_pkg::S_SQ_RUN: begin
                if (r_it == IT_W'(ITER - 1))
                    n_state = (r_leg == 2'd2) ? cbs_pkg::S_DIV : cbs_pkg::S_SQ_LOAD;
            end
            cbs_pkg::S_DIV:     if (r_dn == 6'(TOT_W - 1)) n_state = cbs_pkg::S_PUSH;
            cbs_pkg::S_PUSH: begin
                if (r_count == '0) n_state = cbs_pkg::S_IDLE;
                else if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = cbs_pkg::S_IDLE;
                end
            end
            default: n_state = cbs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= cbs_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // square root one result bit per cycle, then restoring division a bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            cbs_pkg::S_IDLE: begin
                r_pts <= {in_ch.p3_y[COORD_BITS-1:0], in_ch.p3_x[COORD_BITS-1:0],
                          in_ch.p2_y[COORD_BITS-1:0], in_ch.p2_x[COORD_BITS-1:0],
                          in_ch.p1_y[COORD_BITS-1:0], in_ch.p1_x[COORD_BITS-1:0],
                          in_ch.p0_y[COORD_BITS-1:0], in_ch.p0_x[COORD_BITS-1:0]};
                r_leg <= 2'd0;
                r_tot <= '0;
            end
            cbs_pkg::S_SQ_LOAD: begin
                r_rem <= sq;
                r_res <= '0;
                r_bit <= SQ_W'(1) << (2 * ((SQ_W - 1) / 2));
                r_it  <= '0;
            end
            cbs_pkg::S_SQ_RUN: begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_it  <= r_it + 1'b1;
                if (r_it == IT_W'(ITER - 1)) begin
                    r_tot <= r_tot + TOT_W'((r_rem >= trial) ? (r_res >> 1) + r_bit
                                                              : r_res >> 1);
                    r_leg <= r_leg + 1'b1;
                    r_drem <= '0;
                    r_dn   <= '0;
                end
            end
            cbs_pkg::S_DIV: begin
                if (dsh >= (DIV_W+1)'(divisor)) r_drem <= TOT_W'(dsh - (DIV_W+1)'(divisor));
                else                            r_drem <= dsh[TOT_W-1:0];
                r_quo <= {r_quo[TOT_W-2:0], dsh >= (DIV_W+1)'(divisor)};
                r_tot <= r_tot << 1;
                r_dn  <= r_dn + 1'b1;
                if (r_dn == 6'(TOT_W - 1)) begin
                    if ({r_quo[TOT_W-2:0], dsh >= (DIV_W+1)'(divisor)} > TOT_W'(MAX_POINTS))
                        r_count <= cbs_pkg::CNT_W'(MAX_POINTS);
                    else
                        r_count <= cbs_pkg::CNT_W'({r_quo[TOT_W-2:0],
                                                   dsh >= (DIV_W+1)'(divisor)});
                end
            end
            default: ;
        endcase
    end
endmodule

>>> sv/cbs_queue.sv
// ----------------------------------------------------------------------------
// cbs_queue
// two-entry queue of curve jobs (points and count) between front and back
// ----------------------------------------------------------------------------
module cbs_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

>>> sv/cbs_back.sv
// ----------------------------------------------------------------------------
// cbs_back
// evaluates each sample of a queued curve by de casteljau and emits it
// ----------------------------------------------------------------------------
module cbs_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  logic [8*COORD_BITS-1:0]   i_pts,
    input  logic [cbs_pkg::CNT_W-1:0] i_count,
    output logic                      o_pop,
    cbs_out_if.source                 out_ch
);
    localparam int T  = cbs_pkg::T_BITS;
    localparam int VW = COORD_BITS + T + 1;
    localparam int CW = cbs_pkg::CNT_W;
    localparam int NW = T + CW;

    cbs_pkg::t_back_state r_state, n_state;
    logic [CW-1:0] r_i;
    logic [NW-1:0] r_num;
    logic [T:0]    r_t;
    logic [CW-1:0] r_rem;
    logic [4:0]    r_k;
    logic [2:0]    r_step;
    logic [COORD_BITS-1:0] r_v [2][4];
    logic [VW-1:0] r_fx, r_fy;
    logic          r_v_out;

    logic [CW:0] dsh;
    logic [VW-1:0] lx, ly;
    logic [1:0] ja;

    function automatic logic [VW-1:0] lerp(input logic [COORD_BITS-1:0] a,
                                            input logic [COORD_BITS-1:0] b,
                                            input logic [T:0] t);
        logic [VW-1:0] base;
        base = VW'(a) << T;
        if (b >= a) lerp = base + VW'(VW'(b - a) * VW'(t));
        else        lerp = base - VW'(VW'(a - b) * VW'(t));
    endfunction

    assign dsh = {r_rem, r_num[NW-1]};

    // step codes 0..2 first level, 3..4 second, 5 last; ja picks the pair
    always_comb begin
        case (r_step)
            3'd0, 3'd3, 3'd5: ja = 2'd0;
            3'd1, 3'd4:       ja = 2'd1;
            3'd2:             ja = 2'd2;
            default:          ja = 2'd0;
        endcase
    end

    assign lx  = lerp(r_v[0][ja], r_v[0][ja + 2'd1], r_t);
    assign ly  = lerp(r_v[1][ja], r_v[1][ja + 2'd1], r_t);

    assign out_ch.valid = r_v_out;
    assign out_ch.sample_index = r_i[5:0];
    assign out_ch.last = (r_i + 1'b1 == i_count);
    assign out_ch.point_x = (r_fx >> (T - FRAC_BITS)) > VW'(24'hFFFFFF) ? 24'hFFFFFF
                          : 24'(r_fx >> (T - FRAC_BITS));
    assign out_ch.point_y = (r_fy >> (T - FRAC_BITS)) > VW'(24'hFFFFFF) ? 24'hFFFFFF
                          : 24'(r_fy >> (T - FRAC_BITS));

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            cbs_pkg::B_IDLE: if (!i_empty) n_state = cbs_pkg::B_TDIV;
            cbs_pkg::B_TDIV: if (r_k == 5'(NW - 1)) n_state = cbs_pkg::B_LERP;
            // lerp levels: three, two, then one lerp per axis, one per cycle
            cbs_pkg::B_LERP: if (r_step == 3'd5) n_state = cbs_pkg::B_OUT;
            cbs_pkg::B_OUT: begin
                if (!r_v_out) begin
                    if (out_ch.last) begin
                        o_pop   = 1'b1;
                        n_state = cbs_pkg::B_IDLE;
                    end else begin
                        n_state = cbs_pkg::B_TDIV;
                    end
                end
            end
            default: n_state = cbs_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbs_pkg::B_IDLE;
            r_v_out <= 1'b0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            if (out_ch.valid && out_ch.ready) r_v_out <= 1'b0;
            else if (r_state == cbs_pkg::B_LERP && r_step == 3'd5) r_v_out <= 1'b1;
            if (r_state == cbs_pkg::B_IDLE) r_i <= '0;
            else if (r_state == cbs_pkg::B_OUT && !r_v_out) r_i <= r_i + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cbs_pkg::B_IDLE, cbs_pkg::B_OUT: begin
                r_num <= (r_state == cbs_pkg::B_IDLE) ? '0
                         : NW'(r_i + 1'b1) << T;
                r_rem <= '0;
                r_k   <= '0;
            end
            cbs_pkg::B_TDIV: begin
                if (dsh >= (CW+1)'(i_count)) r_rem <= CW'(dsh - (CW+1)'(i_count));
                else                         r_rem <= dsh[CW-1:0];
                r_num <= {r_num[NW-2:0], dsh >= (CW+1)'(i_count)};
                r_k   <= r_k + 1'b1;
                if (r_k == 5'(NW - 1)) begin
                    r_t <= (T+1)'({r_num[NW-2:0], dsh >= (CW+1)'(i_count)});
                    for (int a = 0; a < 2; a++)
                        for (int p = 0; p < 4; p++)
                            r_v[a][p] <= i_pts[(2*p+a)*COORD_BITS +: COORD_BITS];
                end
                r_step <= '0;
            end
            cbs_pkg::B_LERP: begin
                r_step <= r_step + 1'b1;
                if (r_step == 3'd5) begin
                    r_fx <= lx;
                    r_fy <= ly;
                end else begin
                    r_v[0][ja] <= COORD_BITS'(lx >> T);
                    r_v[1][ja] <= COORD_BITS'(ly >> T);
                end
            end
            default: ;
        endcase
    end
endmodule
